// File: rtl/core/event_listener_table_dispatch_unit_assert.svh
// assertion macros for the listener table
`ifndef EVENT_LISTENER_TABLE_DISPATCH_UNIT_ASSERT_SVH
`define EVENT_LISTENER_TABLE_DISPATCH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define ELT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("listener table assertion failed");

`define ELT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("listener table assertion failed");

`else

`define ELT_ASSERT_IMP(lbl, ante, cons)

`define ELT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: rtl/core/elt_pkg.sv
`default_nettype none

package elt_pkg;

  localparam logic [2:0] MODE_ADD_APPEND = 3'd0;
  localparam logic [2:0] MODE_ADD_OVER   = 3'd1;
  localparam logic [2:0] MODE_REMOVE     = 3'd2;
  localparam logic [2:0] MODE_SET_EN     = 3'd3;
  localparam logic [2:0] MODE_QUERY      = 3'd4;
  localparam logic [2:0] MODE_DISPATCH   = 3'd5;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_HANDLER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_ENABLE  = 1'b1;

  typedef struct packed {
    logic [15:0] code;
    logic [7:0]  handler;
    logic        en;
  } entry_t;

  typedef struct packed {
    logic code_eq;
    logic h_eq;
    logic h_nz;
    logic en;
  } cmp_t;

endpackage

`default_nettype wire

// File: rtl/core/elt_ram.sv
`default_nettype none

module elt_ram #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/elt_cmp.sv
`default_nettype none

module elt_cmp (
  input  wire logic            [15:0] code_i,
  input  wire logic            [7:0]  handler_i,
  input  wire elt_pkg::entry_t        entry_i,
  output elt_pkg::cmp_t               cmp_o
);

  always_comb begin
    cmp_o.code_eq = (entry_i.code == code_i);
    cmp_o.h_eq    = (entry_i.handler == handler_i);
    cmp_o.h_nz    = (entry_i.handler != 8'd0);
    cmp_o.en      = entry_i.en;
  end

endmodule

`default_nettype wire

// File: rtl/core/event_listener_table_dispatch_unit.sv
// channel   direction  handshake                        payload
// command   in         start_i high while busy_o low    mode_i, event_code_i, handler_id_i,
//                                                       enable_value_i, event_param_i
// result    out        res_valid_o for one cycle        is_call_o, ok_o, call_handler_o,
//                                                       call_code_o, call_param_o, last_o
// config    in         cfg_valid_i and cfg_ready_o      cfg_index_i, cfg_data_i
//
// add append, unused modes and add overwrite with handler 0: answer next cycle, never busy.
// other modes read one entry per cycle through the single ram read port and stay busy
// until the scan ends or, except for dispatch, stops at a hit; remove then shifts the later
// entries down. dispatch calls come out during the scan, last at end.
// rst_ni clears the entry count and config registers; the table itself is not cleared.
// the receiver cannot stall, config is always ready.
`default_nettype none

`include "event_listener_table_dispatch_unit_assert.svh"

module event_listener_table_dispatch_unit #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic        [2:0]             mode_i,
  input  wire logic signed [15:0]            event_code_i,
  input  wire logic        [7:0]             handler_id_i,
  input  wire logic                          enable_value_i,
  input  wire logic signed [15:0]            event_param_i,
  output logic                               res_valid_o,
  output logic                               is_call_o,
  output logic                               ok_o,
  output logic             [7:0]             call_handler_o,
  output logic signed      [15:0]            call_code_o,
  output logic signed      [15:0]            call_param_o,
  output logic                               last_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [elt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic        [7:0]             cfg_data_i
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = $bits(elt_pkg::entry_t);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [2:0]         op_mode_q, op_mode_d;
  logic [15:0]        op_code_q, op_code_d;
  logic [7:0]         op_h_q, op_h_d;
  logic               op_en_q, op_en_d;
  logic [15:0]        op_param_q, op_param_d;
  logic [CW-1:0]      rd_idx_q, rd_idx_d;
  logic [CW-1:0]      count_q, count_d;
  logic               chk_vld_q, chk_vld_d;
  logic [AW-1:0]      chk_idx_q, chk_idx_d;
  logic               pend_q, pend_d;
  logic [7:0]         pend_h_q, pend_h_d;
  logic [7:0]         def_h_q;
  logic               def_en_q;

  logic               res_vld_q, res_vld_d;
  logic               is_call_q, is_call_d;
  logic               ok_q, ok_d;
  logic [7:0]         handler_q, handler_d;
  logic [15:0]        code_q, code_d;
  logic [15:0]        param_q, param_d;
  logic               last_q, last_d;

  logic               issue;
  logic               we;
  logic [AW-1:0]      waddr;
  elt_pkg::entry_t    wdata;
  logic [AW-1:0]      raddr;
  logic [EW-1:0]      rdata;
  elt_pkg::entry_t    rd_entry;
  elt_pkg::cmp_t      cmp;

  assign rd_entry = elt_pkg::entry_t'(rdata);

  elt_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  elt_cmp u_cmp (
    .code_i    (op_code_q),
    .handler_i (op_h_q),
    .entry_i   (rd_entry),
    .cmp_o     (cmp)
  );

  always_comb begin
    state_d    = state_q;
    op_mode_d  = op_mode_q;
    op_code_d  = op_code_q;
    op_h_d     = op_h_q;
    op_en_d    = op_en_q;
    op_param_d = op_param_q;
    rd_idx_d   = rd_idx_q;
    count_d    = count_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = rd_idx_q[AW-1:0];
    pend_d     = pend_q;
    pend_h_d   = pend_h_q;
    issue      = 1'b0;
    we         = 1'b0;
    waddr      = count_q[AW-1:0];
    wdata      = '0;
    raddr      = rd_idx_q[AW-1:0];
    res_vld_d  = 1'b0;
    is_call_d  = 1'b0;
    ok_d       = 1'b0;
    handler_d  = 8'd0;
    code_d     = 16'd0;
    param_d    = 16'd0;
    last_d     = 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_mode_d  = mode_i;
          op_code_d  = event_code_i;
          op_h_d     = handler_id_i;
          op_en_d    = enable_value_i;
          op_param_d = event_param_i;
          rd_idx_d   = '0;
          pend_d     = 1'b0;
          case (mode_i)
            elt_pkg::MODE_ADD_APPEND: begin
              res_vld_d = 1'b1;
              if (handler_id_i != 8'd0 && count_q < DEPTH_C) begin
                we      = 1'b1;
                wdata   = '{code: event_code_i, handler: handler_id_i, en: 1'b1};
                count_d = count_q + CW'(1);
                ok_d    = 1'b1;
              end
            end
            elt_pkg::MODE_ADD_OVER: begin
              if (handler_id_i == 8'd0) begin
                res_vld_d = 1'b1;
              end else begin
                state_d = ST_SCAN;
              end
            end
            default: begin
              if (mode_i inside {elt_pkg::MODE_REMOVE, elt_pkg::MODE_SET_EN,
                                 elt_pkg::MODE_QUERY, elt_pkg::MODE_DISPATCH}) begin
                state_d = ST_SCAN;
              end else begin
                res_vld_d = 1'b1;
              end
            end
          endcase
        end
      end

      ST_SCAN: begin
        issue     = rd_idx_q < count_q;
        chk_vld_d = issue;
        if (issue) begin
          rd_idx_d = rd_idx_q + CW'(1);
        end
        if (chk_vld_q) begin
          if (op_mode_q == elt_pkg::MODE_DISPATCH) begin
            if (cmp.code_eq && cmp.en && cmp.h_nz) begin
              if (pend_q) begin
                res_vld_d = 1'b1;
                is_call_d = 1'b1;
                ok_d      = 1'b1;
                handler_d = pend_h_q;
                code_d    = op_code_q;
                param_d   = op_param_q;
                last_d    = 1'b0;
              end
              pend_d   = 1'b1;
              pend_h_d = rd_entry.handler;
            end
          end else if (cmp.code_eq && (cmp.h_eq || op_mode_q == elt_pkg::MODE_ADD_OVER)) begin
            chk_vld_d = 1'b0;
            state_d   = ST_IDLE;
            case (op_mode_q)
              elt_pkg::MODE_ADD_OVER: begin
                we        = 1'b1;
                waddr     = chk_idx_q;
                wdata     = '{code: op_code_q, handler: op_h_q, en: 1'b1};
                res_vld_d = 1'b1;
                ok_d      = 1'b1;
              end
              elt_pkg::MODE_SET_EN: begin
                we        = 1'b1;
                waddr     = chk_idx_q;
                wdata     = '{code: op_code_q, handler: op_h_q, en: op_en_q};
                res_vld_d = 1'b1;
                ok_d      = 1'b1;
              end
              elt_pkg::MODE_QUERY: begin
                res_vld_d = 1'b1;
                ok_d      = cmp.en;
              end
              elt_pkg::MODE_REMOVE: begin
                state_d  = ST_SHIFT;
                rd_idx_d = CW'(chk_idx_q) + CW'(1);
              end
              default: begin
                res_vld_d = 1'b1;
              end
            endcase
          end
        end else if (!issue) begin
          state_d = ST_IDLE;
          case (op_mode_q)
            elt_pkg::MODE_ADD_OVER: begin
              res_vld_d = 1'b1;
              if (count_q < DEPTH_C) begin
                we      = 1'b1;
                wdata   = '{code: op_code_q, handler: op_h_q, en: 1'b1};
                count_d = count_q + CW'(1);
                ok_d    = 1'b1;
              end
            end
            elt_pkg::MODE_DISPATCH: begin
              code_d  = op_code_q;
              param_d = op_param_q;
              ok_d    = 1'b1;
              if (pend_q) begin
                res_vld_d = 1'b1;
                is_call_d = 1'b1;
                handler_d = pend_h_q;
              end else if (def_h_q != 8'd0 && def_en_q) begin
                res_vld_d = 1'b1;
                is_call_d = 1'b1;
                handler_d = def_h_q;
              end
            end
            default: begin
              res_vld_d = 1'b1;
            end
          endcase
        end
      end

      ST_SHIFT: begin
        issue     = rd_idx_q < count_q;
        chk_vld_d = issue;
        if (issue) begin
          rd_idx_d = rd_idx_q + CW'(1);
        end
        if (chk_vld_q) begin
          we    = 1'b1;
          waddr = chk_idx_q - AW'(1);
          wdata = rd_entry;
        end else if (!issue) begin
          state_d   = ST_IDLE;
          count_d   = count_q - CW'(1);
          res_vld_d = 1'b1;
          ok_d      = 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      chk_vld_q <= 1'b0;
      pend_q    <= 1'b0;
      res_vld_q <= 1'b0;
      def_h_q   <= 8'd0;
      def_en_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      chk_vld_q <= chk_vld_d;
      pend_q    <= pend_d;
      res_vld_q <= res_vld_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          elt_pkg::CFG_DEF_HANDLER: def_h_q  <= cfg_data_i;
          elt_pkg::CFG_DEF_ENABLE:  def_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_mode_q  <= op_mode_d;
    op_code_q  <= op_code_d;
    op_h_q     <= op_h_d;
    op_en_q    <= op_en_d;
    op_param_q <= op_param_d;
    rd_idx_q   <= rd_idx_d;
    chk_idx_q  <= chk_idx_d;
    pend_h_q   <= pend_h_d;
    is_call_q  <= is_call_d;
    ok_q       <= ok_d;
    handler_q  <= handler_d;
    code_q     <= code_d;
    param_q    <= param_d;
    last_q     <= last_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign res_valid_o    = res_vld_q;
  assign is_call_o      = is_call_q;
  assign ok_o           = ok_q;
  assign call_handler_o = handler_q;
  assign call_code_o    = code_q;
  assign call_param_o   = param_q;
  assign last_o         = last_q;

  // table never overfills
  `ELT_ASSERT_IMP(a_count_max, 1'b1, count_q <= DEPTH_C)
  // answers are single beats
  `ELT_ASSERT_IMP(a_answer_last, res_vld_q && !is_call_q, last_q)
  // dispatch always enters the scan
  `ELT_ASSERT_NXT(a_dispatch_scan, start_i && !busy_o && mode_i == elt_pkg::MODE_DISPATCH,
                  busy_o)
  // shift always ends with a successful answer as it goes idle
  `ELT_ASSERT_NXT(a_shift_done, state_q == ST_SHIFT && state_d == ST_IDLE,
                  res_vld_q && ok_q && !is_call_q)

endmodule

`default_nettype wire

// File: bench/event_listener_table_dispatch_checker.sv
`timescale 1ns / 1ps

module event_listener_table_dispatch_checker #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_o,
  input  logic [2:0]                    mode_i,
  input  logic [15:0]                   event_code_i,
  input  logic [7:0]                    handler_id_i,
  input  logic                          enable_value_i,
  input  logic [15:0]                   event_param_i,
  input  logic                          res_valid_o,
  input  logic                          is_call_o,
  input  logic                          ok_o,
  input  logic [7:0]                    call_handler_o,
  input  logic [15:0]                   call_code_o,
  input  logic [15:0]                   call_param_o,
  input  logic                          last_o,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [elt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  typedef struct packed {
    logic        is_call;
    logic        ok;
    logic [7:0]  handler;
    logic [15:0] code;
    logic [15:0] param;
    logic        last;
  } listener_result_t;

  elt_pkg::entry_t  listener_tbl [TABLE_DEPTH];
  int unsigned      listener_cnt;
  logic [7:0]       dflt_handler;
  logic             dflt_enable;
  listener_result_t expected_results [$];

  function automatic int find_listener(logic [15:0] code, logic [7:0] h, bit match_handler);
    int i;
    for (i = 0; i < int'(listener_cnt); i++) begin
      if (listener_tbl[i].code == code && (!match_handler || listener_tbl[i].handler == h))
        return i;
    end
    return -1;
  endfunction

  function automatic bit listener_fires(int i, logic [15:0] code);
    return listener_tbl[i].handler != 8'd0 && listener_tbl[i].code == code &&
           listener_tbl[i].en;
  endfunction

  task automatic predict_command(logic [2:0] mode, logic [15:0] code, logic [7:0] h,
                                 logic en, logic [15:0] param);
    int  i;
    int  k;
    int  n_calls;
    logic ok;
    ok = 1'b0;
    if (mode == elt_pkg::MODE_DISPATCH) begin
      n_calls = 0;
      for (i = 0; i < int'(listener_cnt); i++)
        if (listener_fires(i, code)) n_calls++;
      if (n_calls != 0) begin
        k = 0;
        for (i = 0; i < int'(listener_cnt); i++) begin
          if (listener_fires(i, code)) begin
            expected_results.push_back('{1'b1, 1'b1, listener_tbl[i].handler, code, param,
                                         k == n_calls - 1});
            k++;
          end
        end
      end else if (dflt_handler != 8'd0 && dflt_enable) begin
        expected_results.push_back('{1'b1, 1'b1, dflt_handler, code, param, 1'b1});
      end
    end else begin
      case (mode)
        elt_pkg::MODE_ADD_APPEND, elt_pkg::MODE_ADD_OVER: begin
          if (h != 8'd0) begin
            k = (mode == elt_pkg::MODE_ADD_OVER) ? find_listener(code, h, 1'b0) : -1;
            if (k >= 0) begin
              listener_tbl[k].handler = h;
              listener_tbl[k].en = 1'b1;
              ok = 1'b1;
            end else if (listener_cnt < TABLE_DEPTH) begin
              listener_tbl[listener_cnt] = '{code, h, 1'b1};
              listener_cnt++;
              ok = 1'b1;
            end
          end
        end
        elt_pkg::MODE_REMOVE: begin
          k = find_listener(code, h, 1'b1);
          if (k >= 0) begin
            for (i = k; i + 1 < int'(listener_cnt); i++)
              listener_tbl[i] = listener_tbl[i+1];
            listener_cnt--;
            ok = 1'b1;
          end
        end
        elt_pkg::MODE_SET_EN: begin
          k = find_listener(code, h, 1'b1);
          if (k >= 0) begin
            listener_tbl[k].en = en;
            ok = 1'b1;
          end
        end
        elt_pkg::MODE_QUERY: begin
          k = find_listener(code, h, 1'b1);
          if (k >= 0) ok = listener_tbl[k].en;
        end
        default: ok = 1'b0;
      endcase
      expected_results.push_back('{1'b0, ok, 8'd0, 16'd0, 16'd0, 1'b1});
    end
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    listener_result_t want;
    if (!rst_ni) begin
      listener_cnt = 0;
      dflt_handler = 8'd0;
      dflt_enable = 1'b0;
      expected_results.delete();
    end else begin
      if (res_valid_o) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result expected none got call %0b ok %0b handler %0h",
                   $time, is_call_o, ok_o, call_handler_o);
          $display("%0t: result code %0h param %0h last %0b",
                   $time, call_code_o, call_param_o, last_o);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("is_call", 16'(want.is_call), 16'(is_call_o));
          check_field("ok", 16'(want.ok), 16'(ok_o));
          check_field("call_handler", 16'(want.handler), 16'(call_handler_o));
          check_field("call_code", want.code, call_code_o);
          check_field("call_param", want.param, call_param_o);
          check_field("last", 16'(want.last), 16'(last_o));
        end
      end
      if (start_i && !busy_o)
        predict_command(mode_i, event_code_i, handler_id_i, enable_value_i, event_param_i);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          elt_pkg::CFG_DEF_HANDLER: dflt_handler = cfg_data_i;
          elt_pkg::CFG_DEF_ENABLE:  dflt_enable = cfg_data_i[0];
          default:                  dflt_enable = dflt_enable;
        endcase
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// File: bench/event_listener_table_dispatch_unit_tb.sv
`timescale 1ns / 1ps

module event_listener_table_dispatch_unit_tb;

  localparam logic [2:0]  MODE_SPARE_6 = 3'd6;
  localparam logic [2:0]  MODE_SPARE_7 = 3'd7;
  localparam logic [15:0] CODE_MIN     = 16'h8000;
  localparam logic [15:0] CODE_MAX     = 16'h7fff;
  localparam int          SETTLE_CYCLES = 48;
  localparam int          CYCLE_LIMIT  = 200000;

  typedef enum int {EP_FILL, EP_DRAIN, EP_MIXED} episode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [2:0]  mode_i = elt_pkg::MODE_QUERY;
  logic [15:0] event_code_i = 16'd0;
  logic [7:0]  handler_id_i = 8'd0;
  logic        enable_value_i = 1'b0;
  logic [15:0] event_param_i = 16'd0;
  logic        cfg_valid_i = 1'b0;
  logic [elt_pkg::CFG_IDX_W-1:0] cfg_index_i = elt_pkg::CFG_DEF_HANDLER;
  logic [7:0]  cfg_data_i = 8'd0;

  wire         busy_o;
  wire         res_valid_o;
  wire         is_call_o;
  wire         ok_o;
  wire [7:0]   call_handler_o;
  wire [15:0]  call_code_o;
  wire [15:0]  call_param_o;
  wire         last_o;
  wire         cfg_ready_o;

  int fail_count;
  int pending;
  int gap_pct = 0;
  int cycles = 0;

  event_listener_table_dispatch_unit #(.TABLE_DEPTH(16)) dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .mode_i, .event_code_i, .handler_id_i,
    .enable_value_i, .event_param_i, .res_valid_o, .is_call_o, .ok_o, .call_handler_o,
    .call_code_o, .call_param_o, .last_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i,
    .cfg_data_i
  );

  event_listener_table_dispatch_checker #(.TABLE_DEPTH(16)) results_chk (
    .clk_i, .rst_ni, .start_i, .busy_o, .mode_i, .event_code_i, .handler_id_i,
    .enable_value_i, .event_param_i, .res_valid_o, .is_call_o, .ok_o, .call_handler_o,
    .call_code_o, .call_param_o, .last_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("event_listener_table_dispatch_unit_tb NOT OK");
      $finish;
    end
  end

  task automatic send_cmd(logic [2:0] mode, logic [15:0] code, logic [7:0] h, logic en,
                          logic [15:0] param);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i        <= 1'b1;
    mode_i         <= mode;
    event_code_i   <= code;
    handler_id_i   <= h;
    enable_value_i <= en;
    event_param_i  <= param;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_defaults(logic [7:0] handler, logic enable);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= elt_pkg::CFG_DEF_HANDLER;
    cfg_data_i  <= handler;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_index_i <= elt_pkg::CFG_DEF_ENABLE;
    cfg_data_i  <= {7'd0, enable};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // drain outstanding results, then cover dispatches that never answer
  task automatic settle();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_code(bit narrow);
    int r;
    r = $urandom_range(15);
    if (r == 0) return 16'($urandom);
    case (narrow ? r % 2 : r % 4)
      0:       return CODE_MIN;
      1:       return CODE_MAX;
      2:       return 16'hffff;
      default: return 16'h0007;
    endcase
  endfunction

  function automatic logic [7:0] pick_handler();
    int r;
    r = $urandom_range(15);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'($urandom_range(1, 255));
    case (r % 4)
      0:       return 8'd1;
      1:       return 8'd2;
      2:       return 8'd128;
      default: return 8'd255;
    endcase
  endfunction

  function automatic logic [2:0] pick_mode(episode_e ep);
    int r;
    r = $urandom_range(99);
    case (ep)
      EP_FILL: begin
        if (r < 50) return elt_pkg::MODE_ADD_APPEND;
        if (r < 70) return elt_pkg::MODE_ADD_OVER;
        if (r < 82) return elt_pkg::MODE_DISPATCH;
        if (r < 91) return elt_pkg::MODE_QUERY;
        return elt_pkg::MODE_SET_EN;
      end
      EP_DRAIN: begin
        if (r < 50) return elt_pkg::MODE_REMOVE;
        if (r < 70) return elt_pkg::MODE_DISPATCH;
        if (r < 80) return elt_pkg::MODE_SET_EN;
        if (r < 90) return elt_pkg::MODE_ADD_APPEND;
        return elt_pkg::MODE_QUERY;
      end
      default: begin
        if (r < 20) return elt_pkg::MODE_ADD_APPEND;
        if (r < 30) return elt_pkg::MODE_ADD_OVER;
        if (r < 45) return elt_pkg::MODE_REMOVE;
        if (r < 57) return elt_pkg::MODE_SET_EN;
        if (r < 69) return elt_pkg::MODE_QUERY;
        if (r < 95) return elt_pkg::MODE_DISPATCH;
        return (r < 97) ? MODE_SPARE_6 : MODE_SPARE_7;
      end
    endcase
  endfunction

  task automatic run_phase(int n_items, int idle_pct);
    int       sent;
    int       len;
    episode_e ep;
    sent = 0;
    gap_pct = idle_pct;
    while (sent < n_items) begin
      ep = episode_e'($urandom_range(2));
      len = $urandom_range(8, 20);
      repeat (len) begin
        if (sent < n_items) begin
          send_cmd(pick_mode(ep), pick_code(ep == EP_FILL), pick_handler(),
                   1'($urandom_range(1)), 16'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_defaults(8'd255, 1'b1);

    gap_pct = 8;
    send_cmd(elt_pkg::MODE_QUERY,      16'd0,    8'd1,   1'b0, 16'd0);
    send_cmd(elt_pkg::MODE_DISPATCH,   16'd0,    8'd0,   1'b0, 16'h1234);
    send_cmd(elt_pkg::MODE_ADD_APPEND, 16'd9,    8'd0,   1'b0, 16'd0);
    send_cmd(elt_pkg::MODE_ADD_APPEND, CODE_MIN, 8'd255, 1'b0, 16'd0);
    send_cmd(elt_pkg::MODE_ADD_APPEND, CODE_MAX, 8'd1,   1'b0, 16'd0);
    send_cmd(elt_pkg::MODE_ADD_OVER,   CODE_MAX, 8'd2,   1'b0, 16'd0);
    send_cmd(elt_pkg::MODE_ADD_OVER,   16'd5,    8'd0,   1'b0, 16'd0);
    send_cmd(elt_pkg::MODE_QUERY,      CODE_MAX, 8'd2,   1'b0, 16'd0);
    send_cmd(elt_pkg::MODE_SET_EN,     CODE_MAX, 8'd2,   1'b0, 16'd0);
    send_cmd(elt_pkg::MODE_QUERY,      CODE_MAX, 8'd2,   1'b1, 16'd0);
    send_cmd(elt_pkg::MODE_SET_EN,     CODE_MAX, 8'd0,   1'b1, 16'd0);
    send_cmd(elt_pkg::MODE_QUERY,      CODE_MAX, 8'd0,   1'b0, 16'd0);
    send_cmd(elt_pkg::MODE_REMOVE,     CODE_MAX, 8'd0,   1'b0, 16'd0);
    send_cmd(elt_pkg::MODE_DISPATCH,   CODE_MAX, 8'd0,   1'b0, CODE_MIN);
    send_cmd(elt_pkg::MODE_ADD_APPEND, CODE_MIN, 8'd3,   1'b0, 16'd0);
    send_cmd(elt_pkg::MODE_ADD_APPEND, CODE_MIN, 8'd128, 1'b0, 16'd0);
    send_cmd(elt_pkg::MODE_DISPATCH,   CODE_MIN, 8'd0,   1'b0, CODE_MAX);
    send_cmd(elt_pkg::MODE_REMOVE,     CODE_MIN, 8'd3,   1'b0, 16'd0);
    send_cmd(elt_pkg::MODE_REMOVE,     CODE_MIN, 8'd3,   1'b0, 16'd0);
    send_cmd(elt_pkg::MODE_SET_EN,     CODE_MAX, 8'd2,   1'b1, 16'd0);
    send_cmd(elt_pkg::MODE_ADD_OVER,   CODE_MAX, 8'd85,  1'b0, 16'd0);
    send_cmd(elt_pkg::MODE_DISPATCH,   CODE_MAX, 8'd0,   1'b0, 16'hffff);
    send_cmd(MODE_SPARE_6,             16'hffff, 8'd255, 1'b1, 16'hffff);
    send_cmd(MODE_SPARE_7,             CODE_MIN, 8'd1,   1'b0, 16'd0);
    send_cmd(elt_pkg::MODE_DISPATCH,   16'd1,    8'd0,   1'b0, 16'd0);
    settle();

    write_defaults(8'd0, 1'b1);
    run_phase(65, 8);
    settle();

    write_defaults(8'($urandom_range(1, 254)), 1'b0);
    run_phase(65, 76);
    settle();

    write_defaults(8'($urandom_range(1, 255)), 1'b1);
    run_phase(65, 0);
    settle();

    if (fail_count == 0) begin
      $display("event_listener_table_dispatch_unit_tb OK");
    end else begin
      $display("event_listener_table_dispatch_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/elt_pkg.sv
rtl/core/elt_ram.sv
rtl/core/elt_cmp.sv
rtl/core/event_listener_table_dispatch_unit.sv
bench/event_listener_table_dispatch_checker.sv
bench/event_listener_table_dispatch_unit_tb.sv
